[rtl/pip_pkg.sv]
// ----------------------------------------------------------------------------
// pip_pkg: shared types and codes of the point-in-polygon test
// Command, view plane and register codes, and the control and status groups
// passed between the sequencer and the edge unit.
// ----------------------------------------------------------------------------
package pip_pkg;

    // Command codes of an input beat
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // View plane codes (the unused code behaves as axial)
    localparam logic [1:0] VIEW_AXIAL    = 2'd0;
    localparam logic [1:0] VIEW_SAGITTAL = 2'd1;
    localparam logic [1:0] VIEW_CORONAL  = 2'd2;

    // Register indexes on the configuration port
    localparam logic REG_VIEW_PLANE   = 1'b0;
    localparam logic REG_VERTEX_COUNT = 1'b1;

    // Field widths fixed by the ports
    localparam int FIELD_BITS      = 16;
    localparam int VIEW_BITS       = 2;
    localparam int COUNT_BITS      = 7;
    localparam int INDEX_BITS      = 6;
    localparam int APB_DATA_BITS   = 32;
    localparam int APB_ADDR_BITS   = 3;

    // Fewest vertices that make a polygon
    localparam int MIN_POLY_VERTICES = 3;

    // Sequencer to edge unit
    typedef struct packed {
        logic issue;   // an edge is presented this cycle
        logic clear;   // reset the crossing parity
    } edge_ctrl_t;

    // Edge unit to sequencer
    typedef struct packed {
        logic busy;    // edges still in flight
        logic parity;  // even-odd crossing parity so far
    } edge_stat_t;

endpackage

[rtl/pip_if.sv]
// ----------------------------------------------------------------------------
// pip_if: stream channels of the point-in-polygon test
// Request channel (load or query beat) and response channel (one result per
// request), each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pip_req_if
    import pip_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [INDEX_BITS-1:0]         vertex_index;
    logic signed [FIELD_BITS-1:0]  coord_a;
    logic signed [FIELD_BITS-1:0]  coord_b;
    logic signed [FIELD_BITS-1:0]  coord_c;

    modport source (
        output valid, cmd, vertex_index, coord_a, coord_b, coord_c,
        input  ready
    );
    modport sink (
        input  valid, cmd, vertex_index, coord_a, coord_b, coord_c,
        output ready
    );
endinterface

interface pip_rsp_if;
    logic valid;
    logic ready;
    logic is_inside;
    logic was_query;

    modport source (
        output valid, is_inside, was_query,
        input  ready
    );
    modport sink (
        input  valid, is_inside, was_query,
        output ready
    );
endinterface

[rtl/point_in_polygon_test.sv]
// ----------------------------------------------------------------------------
// point_in_polygon_test: even-odd crossing test against a stored polygon
// Vertices sit in a ring of cells; a query rotates the ring once past a
// pipelined edge unit and reports the crossing parity.
//
//   channel  dir  beat contents
//   req      in   cmd, vertex_index, coord_a, coord_b, coord_c
//   rsp      out  is_inside, was_query
//   apb      in   view_plane at 0x0, vertex_count at 0x4
//
// A load writes its cell and is acknowledged in the next cycle.
// A query rotates the ring one cell per cycle for a full turn, then waits
// for the three-stage edge unit to drain and the output register to be free.
// One item is in work at a time; a query is accepted while the previous
// result still waits in the output register.
// rst_n clears control and config registers, not the ring or query payload.
// ----------------------------------------------------------------------------
module point_in_polygon_test
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    pip_req_if.sink                   req,
    pip_rsp_if.source                 rsp,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_BITS-1:0]  paddr,
    input  logic [APB_DATA_BITS-1:0]  pwdata,
    output logic [APB_DATA_BITS-1:0]  prdata,
    output logic                      pready
);

    localparam int SW = $clog2(MAX_VERTICES + 1);
    localparam int VW = 3 * COORD_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN
    } state_t;

    // Configuration
    logic [VIEW_BITS-1:0]  view_plane_reg;
    logic [COUNT_BITS-1:0] vertex_count_reg;
    logic                  cfg_write;

    // Sequencer
    state_t                state_reg, state_next;
    logic [SW-1:0]         step_reg, step_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_inside_reg, out_inside_next;
    logic                  out_query_reg, out_query_next;

    // Query payload
    logic [SW-1:0]                 count_reg;
    logic                          few_reg;
    logic signed [COORD_BITS-1:0]  px_reg, py_reg;
    logic signed [COORD_BITS-1:0]  first_x_reg, first_y_reg;
    logic signed [COORD_BITS-1:0]  prev_x_reg, prev_y_reg;

    logic                          out_free;
    logic                          accept, load_fire, query_fire;
    logic                          shift_en;
    logic signed [COORD_BITS-1:0]  in_a, in_b, in_c;
    logic signed [COORD_BITS-1:0]  in_x, in_y;
    logic signed [COORD_BITS-1:0]  head_a, head_b, head_c;
    logic signed [COORD_BITS-1:0]  head_x, head_y;
    logic [VW-1:0]                 load_vtx;
    logic [VW-1:0]                 vtx [MAX_VERTICES];
    edge_ctrl_t                    edge_ctrl;
    edge_stat_t                    edge_stat;
    logic signed [COORD_BITS-1:0]  edge_new_x, edge_new_y;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_plane_reg   <= '0;
            vertex_count_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_VIEW_PLANE:   view_plane_reg   <= pwdata[VIEW_BITS-1:0];
                REG_VERTEX_COUNT: vertex_count_reg <= pwdata[COUNT_BITS-1:0];
                default:          view_plane_reg   <= view_plane_reg;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (paddr[2])
            REG_VIEW_PLANE:   prdata = APB_DATA_BITS'(view_plane_reg);
            REG_VERTEX_COUNT: prdata = APB_DATA_BITS'(vertex_count_reg);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input beat decode
    // ------------------------------------------------------------------
    assign out_free   = !out_valid_reg || rsp.ready;
    assign req.ready  = (state_reg == ST_IDLE) && ((req.cmd == CMD_QUERY) || out_free);
    assign accept     = req.valid && req.ready;
    assign load_fire  = accept && (req.cmd == CMD_LOAD);
    assign query_fire = accept && (req.cmd == CMD_QUERY);

    // Narrow or widen each coordinate to the stored width
    assign in_a     = COORD_BITS'(req.coord_a);
    assign in_b     = COORD_BITS'(req.coord_b);
    assign in_c     = COORD_BITS'(req.coord_c);
    assign load_vtx = {in_c, in_b, in_a};

    // Project the query point and the ring head onto the view plane
    assign head_a = vtx[0][COORD_BITS-1:0];
    assign head_b = vtx[0][2*COORD_BITS-1:COORD_BITS];
    assign head_c = vtx[0][VW-1:2*COORD_BITS];

    always_comb
    begin
        unique case (view_plane_reg)
            VIEW_SAGITTAL:
            begin
                in_x   = in_b;
                in_y   = in_c;
                head_x = head_b;
                head_y = head_c;
            end
            VIEW_CORONAL:
            begin
                in_x   = in_a;
                in_y   = in_c;
                head_x = head_a;
                head_y = head_c;
            end
            default:
            begin
                in_x   = in_a;
                in_y   = in_b;
                head_x = head_a;
                head_y = head_b;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Vertex ring: cell k holds slot k between walks
    // ------------------------------------------------------------------
    assign shift_en = (state_reg == ST_WALK) && (step_reg != SW'(MAX_VERTICES));

    for (genvar k = 0; k < MAX_VERTICES; k++)
    begin : g_ring
        pip_vertex_cell #(
            .COORD_BITS (COORD_BITS)
        ) u_cell (
            .clk       (clk),
            .load_en   (load_fire && (32'(req.vertex_index) == 32'(k))),
            .shift_en  (shift_en),
            .load_vtx  (load_vtx),
            .shift_vtx (vtx[(k + 1) % MAX_VERTICES]),
            .vtx       (vtx[k])
        );
    end

    // ------------------------------------------------------------------
    // Edge feed: edges v[t-1]->v[t] for t in 1..n-1, then v[n-1]->v[0]
    // ------------------------------------------------------------------
    assign edge_ctrl.clear = query_fire;
    assign edge_ctrl.issue = (state_reg == ST_WALK) && (step_reg != '0)
                             && (step_reg <= count_reg);
    assign edge_new_x      = (step_reg == count_reg) ? first_x_reg : head_x;
    assign edge_new_y      = (step_reg == count_reg) ? first_y_reg : head_y;

    pip_edge_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_edge (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (edge_ctrl),
        .old_x  (prev_x_reg),
        .old_y  (prev_y_reg),
        .new_x  (edge_new_x),
        .new_y  (edge_new_y),
        .pt_x   (px_reg),
        .pt_y   (py_reg),
        .stat   (edge_stat)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_inside_next = out_inside_reg;
        out_query_next  = out_query_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (load_fire)
                begin
                    out_valid_next  = 1'b1;
                    out_inside_next = 1'b0;
                    out_query_next  = 1'b0;
                end
                else if (query_fire)
                begin
                    state_next = ST_WALK;
                    step_next  = '0;
                end
            end
            ST_WALK:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == SW'(MAX_VERTICES))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!edge_stat.busy && out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_inside_next = edge_stat.parity && !few_reg;
                    out_query_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_inside_reg <= 1'b0;
            out_query_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            out_valid_reg  <= out_valid_next;
            out_inside_reg <= out_inside_next;
            out_query_reg  <= out_query_next;
        end
    end

    // Latch the query point and count; track first and previous vertices
    always_ff @(posedge clk)
    begin
        if (query_fire)
        begin
            px_reg <= in_x;
            py_reg <= in_y;
            if (32'(vertex_count_reg) > 32'(MAX_VERTICES))
            begin
                count_reg <= SW'(MAX_VERTICES);
            end
            else
            begin
                count_reg <= SW'(vertex_count_reg);
            end
            few_reg <= (32'(vertex_count_reg) < 32'(MIN_POLY_VERTICES));
        end
        if ((state_reg == ST_WALK) && (step_reg == '0))
        begin
            first_x_reg <= head_x;
            first_y_reg <= head_y;
        end
        if (state_reg == ST_WALK)
        begin
            prev_x_reg <= head_x;
            prev_y_reg <= head_y;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.is_inside = out_inside_reg;
    assign rsp.was_query = out_query_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_query_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
        query_fire |=> (state_reg == ST_WALK) && (step_reg == '0))
        else $error("query beat did not start a ring walk");

    a_idle_edge_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !edge_stat.busy)
        else $error("edge unit busy while sequencer idle");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (step_reg <= SW'(MAX_VERTICES)))
        else $error("ring walk ran past one full turn");

    a_drain_reports: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) && !edge_stat.busy && out_free
        |=> out_valid_reg && out_query_reg && (state_reg == ST_IDLE))
        else $error("finished query did not post a result");

endmodule

[rtl/pip_vertex_cell.sv]
// ----------------------------------------------------------------------------
// pip_vertex_cell: one slot of the vertex ring
// Holds one vertex (three coordinates). A load writes it in place; during a
// query walk it takes the vertex of its neighbor so the ring rotates.
// ----------------------------------------------------------------------------
module pip_vertex_cell #(
    parameter int COORD_BITS = 16
) (
    input  logic                      clk,
    input  logic                      load_en,
    input  logic                      shift_en,
    input  logic [3*COORD_BITS-1:0]   load_vtx,
    input  logic [3*COORD_BITS-1:0]   shift_vtx,
    output logic [3*COORD_BITS-1:0]   vtx
);

    logic [3*COORD_BITS-1:0] vtx_reg;
    logic [3*COORD_BITS-1:0] vtx_next;

    // Pick a load, a rotate step or hold
    always_comb
    begin
        vtx_next = vtx_reg;
        if (load_en)
        begin
            vtx_next = load_vtx;
        end
        else if (shift_en)
        begin
            vtx_next = shift_vtx;
        end
    end

    always_ff @(posedge clk)
    begin
        vtx_reg <= vtx_next;
    end

    assign vtx = vtx_reg;

endmodule

[rtl/pip_edge_unit.sv]
// ----------------------------------------------------------------------------
// pip_edge_unit: crossing test of one polygon edge per cycle
// Three stages: span test and differences, two cross products, compare and
// toggle the even-odd parity.
// ----------------------------------------------------------------------------
module pip_edge_unit
    import pip_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  edge_ctrl_t                    ctrl,
    input  logic signed [COORD_BITS-1:0]  old_x,
    input  logic signed [COORD_BITS-1:0]  old_y,
    input  logic signed [COORD_BITS-1:0]  new_x,
    input  logic signed [COORD_BITS-1:0]  new_y,
    input  logic signed [COORD_BITS-1:0]  pt_x,
    input  logic signed [COORD_BITS-1:0]  pt_y,
    output edge_stat_t                    stat
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    logic                   span_hit;
    logic signed [COORD_BITS-1:0] p1_x, p1_y, p2_x, p2_y;
    logic signed [DW-1:0]   dy, dx, ey, ex;

    logic                   s1_valid_reg;
    logic                   s1_hit_reg;
    logic signed [DW-1:0]   s1_dy_reg, s1_dx_reg, s1_ey_reg, s1_ex_reg;
    logic                   s2_valid_reg;
    logic                   s2_hit_reg;
    logic signed [PW-1:0]   s2_lhs_reg, s2_rhs_reg;
    logic                   parity_reg;
    logic                   parity_next;

    // Order the edge end points by x and form the differences
    always_comb
    begin
        span_hit = ((new_x < pt_x) == (pt_x <= old_x));
        if (new_x > old_x)
        begin
            p1_x = old_x;
            p1_y = old_y;
            p2_x = new_x;
            p2_y = new_y;
        end
        else
        begin
            p1_x = new_x;
            p1_y = new_y;
            p2_x = old_x;
            p2_y = old_y;
        end
        dy = DW'(pt_y) - DW'(p1_y);
        dx = DW'(p2_x) - DW'(p1_x);
        ey = DW'(p2_y) - DW'(p1_y);
        ex = DW'(pt_x) - DW'(p1_x);
    end

    // Toggle parity on a crossing edge
    always_comb
    begin
        parity_next = parity_reg;
        if (ctrl.clear)
        begin
            parity_next = 1'b0;
        end
        else if (s2_valid_reg && s2_hit_reg && (s2_lhs_reg < s2_rhs_reg))
        begin
            parity_next = !parity_reg;
        end
    end

    // Stage valids and parity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            parity_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= ctrl.issue;
            s2_valid_reg <= s1_valid_reg;
            parity_reg   <= parity_next;
        end
    end

    // Stage payload: differences, then products
    always_ff @(posedge clk)
    begin
        s1_hit_reg <= span_hit;
        s1_dy_reg  <= dy;
        s1_dx_reg  <= dx;
        s1_ey_reg  <= ey;
        s1_ex_reg  <= ex;
        s2_hit_reg <= s1_hit_reg;
        s2_lhs_reg <= s1_dy_reg * s1_dx_reg;
        s2_rhs_reg <= s1_ey_reg * s1_ex_reg;
    end

    assign stat.busy   = s1_valid_reg || s2_valid_reg;
    assign stat.parity = parity_reg;

endmodule

[verif/point_in_polygon_test_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// point_in_polygon_test_tb: self-checking bench of the point-in-polygon test
// Loads polygons over the request channel, sets plane and vertex count over
// the APB port, and checks every response beat against an even-odd crossing
// predictor kept in the bench. A short directed table runs first, then random
// segments that each load a fresh polygon and fire queries at it, cycling
// through sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module point_in_polygon_test_tb;
    import pip_pkg::*;

    localparam int MAX_VERTICES   = 64;
    localparam int COORD_BITS     = 16;
    localparam int N_DIRECTED     = 27;
    localparam int N_SEGMENTS     = 16;
    localparam int QUERIES_PER_SEG = 95;
    localparam int STALL_LIMIT    = 40 * (MAX_VERTICES + 4);
    localparam int PRINT_LIMIT    = 30;

    typedef logic signed [FIELD_BITS-1:0] coord_t;

    localparam coord_t C_MIN  = 16'sh8000;
    localparam coord_t C_MAX  = 16'sh7fff;
    localparam coord_t C_ZERO = 16'sh0000;
    localparam coord_t C_NEG1 = 16'shffff;
    localparam coord_t C_QPOS = 16'sh4000;
    localparam coord_t C_QNEG = 16'shc000;

    typedef enum logic {ROW_WRITE, ROW_BEAT} row_kind_t;

    // One row of the directed table: a register write or a request beat
    typedef struct packed {
        row_kind_t                kind;
        logic                     reg_sel;
        logic [APB_DATA_BITS-1:0] wdata;
        logic                     cmd;
        logic [INDEX_BITS-1:0]    index;
        coord_t                   a;
        coord_t                   b;
        coord_t                   c;
        logic                     pinned;   // is_inside typed in below
        logic                     in_poly;
    } drow_t;

    typedef struct packed {
        logic pinned;
        logic in_poly;
    } pin_t;

    typedef struct packed {
        logic is_inside;
        logic was_query;
    } answer_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    pip_req_if req_ch ();
    pip_rsp_if rsp_ch ();

    point_in_polygon_test #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: vertex store and register copies
    longint      vtx_store [MAX_VERTICES][3];
    logic [1:0]  view_sel   = VIEW_AXIAL;
    logic [6:0]  poly_count = '0;

    pin_t    staged_pins  [$];   // beats driven but not yet accepted
    answer_t owed_answers [$];   // predicted responses, oldest first

    int mismatch_count = 0;
    int answers_seen   = 0;
    int quiet_cycles   = 0;
    int send_idle_pct  = 0;
    int stall_pct      = 0;

    // Square in the axial and coronal planes, flat line in the sagittal one
    drow_t directed_rows [N_DIRECTED] = '{
        // after reset: no vertices in use
        '{ROW_BEAT,  REG_VIEW_PLANE, 32'd0, CMD_QUERY, 6'd0,  C_ZERO, C_ZERO, C_ZERO, 1'b1, 1'b0},
        '{ROW_BEAT,  REG_VIEW_PLANE, 32'd0, CMD_LOAD,  6'd0,  C_MIN,  C_MIN,  C_MIN,  1'b1, 1'b0},
        '{ROW_BEAT,  REG_VIEW_PLANE, 32'd0, CMD_LOAD,  6'd1,  C_MAX,  C_MIN,  C_MIN,  1'b1, 1'b0},
        '{ROW_BEAT,  REG_VIEW_PLANE, 32'd0, CMD_LOAD,  6'd2,  C_MAX,  C_MAX,  C_MAX,  1'b1, 1'b0},
        '{ROW_BEAT,  REG_VIEW_PLANE, 32'd0, CMD_LOAD,  6'd3,  C_MIN,  C_MAX,  C_MAX,  1'b1, 1'b0},
        // top slot, outside the polygon in use
        '{ROW_BEAT,  REG_VIEW_PLANE, 32'd0, CMD_LOAD,  6'd63, C_MAX,  C_MIN,  C_NEG1, 1'b1, 1'b0},
        // two vertices: always outside
        '{ROW_WRITE, REG_VERTEX_COUNT, 32'd2, CMD_LOAD, 6'd0, C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b0},
        '{ROW_BEAT,  REG_VIEW_PLANE, 32'd0, CMD_QUERY, 6'd0,  C_ZERO, C_ZERO, C_ZERO, 1'b1, 1'b0},
        '{ROW_WRITE, REG_VERTEX_COUNT, 32'd4, CMD_LOAD, 6'd0, C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b0},
        '{ROW_BEAT,  REG_VIEW_PLANE, 32'd0, CMD_QUERY, 6'd0,  C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b0},
        '{ROW_BEAT,  REG_VIEW_PLANE, 32'd0, CMD_QUERY, 6'd63, C_MIN,  C_MIN,  C_MIN,  1'b0, 1'b0},
        '{ROW_BEAT,  REG_VIEW_PLANE, 32'd0, CMD_QUERY, 6'd0,  C_MAX,  C_MAX,  C_MAX,  1'b0, 1'b0},
        '{ROW_BEAT,  REG_VIEW_PLANE, 32'd0, CMD_QUERY, 6'd0,  C_MAX,  C_ZERO, C_ZERO, 1'b0, 1'b0},
        '{ROW_BEAT,  REG_VIEW_PLANE, 32'd0, CMD_QUERY, 6'd0,  C_MIN,  C_ZERO, C_ZERO, 1'b0, 1'b0},
        '{ROW_BEAT,  REG_VIEW_PLANE, 32'd0, CMD_QUERY, 6'd0,  C_ZERO, C_MAX,  C_MIN,  1'b0, 1'b0},
        // sagittal sees a degenerate polygon
        '{ROW_WRITE, REG_VIEW_PLANE, 32'd1, CMD_LOAD,  6'd0,  C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b0},
        '{ROW_BEAT,  REG_VIEW_PLANE, 32'd0, CMD_QUERY, 6'd0,  C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b0},
        '{ROW_WRITE, REG_VIEW_PLANE, 32'd2, CMD_LOAD,  6'd0,  C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b0},
        '{ROW_BEAT,  REG_VIEW_PLANE, 32'd0, CMD_QUERY, 6'd0,  C_ZERO, C_MAX,  C_ZERO, 1'b0, 1'b0},
        '{ROW_BEAT,  REG_VIEW_PLANE, 32'd0, CMD_QUERY, 6'd0,  C_ZERO, C_ZERO, C_MAX,  1'b0, 1'b0},
        // unused view code falls back to axial
        '{ROW_WRITE, REG_VIEW_PLANE, 32'd3, CMD_LOAD,  6'd0,  C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b0},
        '{ROW_BEAT,  REG_VIEW_PLANE, 32'd0, CMD_QUERY, 6'd0,  C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b0},
        // triangle from the first three corners
        '{ROW_WRITE, REG_VERTEX_COUNT, 32'd3, CMD_LOAD, 6'd0, C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b0},
        '{ROW_BEAT,  REG_VIEW_PLANE, 32'd0, CMD_QUERY, 6'd0,  C_QPOS, C_QNEG, C_ZERO, 1'b0, 1'b0},
        '{ROW_BEAT,  REG_VIEW_PLANE, 32'd0, CMD_QUERY, 6'd0,  C_QNEG, C_QPOS, C_ZERO, 1'b0, 1'b0},
        // count written back to zero
        '{ROW_WRITE, REG_VERTEX_COUNT, 32'd0, CMD_LOAD, 6'd0, C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b0},
        '{ROW_BEAT,  REG_VIEW_PLANE, 32'd0, CMD_QUERY, 6'd0,  C_ZERO, C_ZERO, C_ZERO, 1'b1, 1'b0}
    };

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Sign-extend a coordinate from the block's coordinate width
    function automatic longint plane_coord(input coord_t raw);
        longint v;
        v = longint'(raw);
        return (v <<< (64 - COORD_BITS)) >>> (64 - COORD_BITS);
    endfunction

    // Even-odd crossing test of a point against the stored polygon
    function automatic logic polygon_contains(input longint pt [3]);
        int     ax;
        int     ay;
        int     n;
        int     i;
        longint ox;
        longint oy;
        longint nx;
        longint ny;
        longint p1x;
        longint p1y;
        longint p2x;
        longint p2y;
        logic   odd;
        case (view_sel)
            VIEW_SAGITTAL:
            begin
                ax = 1;
                ay = 2;
            end
            VIEW_CORONAL:
            begin
                ax = 0;
                ay = 2;
            end
            default:
            begin
                ax = 0;
                ay = 1;
            end
        endcase
        n = (int'(poly_count) > MAX_VERTICES) ? MAX_VERTICES : int'(poly_count);
        if (n < MIN_POLY_VERTICES)
            return 1'b0;
        odd = 1'b0;
        ox = vtx_store[n-1][ax];
        oy = vtx_store[n-1][ay];
        for (i = 0; i < n; i++)
        begin
            nx = vtx_store[i][ax];
            ny = vtx_store[i][ay];
            // order the edge endpoints by the first in-plane axis
            if (nx > ox)
            begin
                p1x = ox; p1y = oy; p2x = nx; p2y = ny;
            end
            else
            begin
                p1x = nx; p1y = ny; p2x = ox; p2y = oy;
            end
            // half-open span, then the cross-multiplied side test
            if ((nx < pt[ax]) == (pt[ax] <= ox))
            begin
                if ((pt[ay] - p1y) * (p2x - p1x) < (p2y - p1y) * (pt[ax] - p1x))
                    odd = ~odd;
            end
            ox = nx;
            oy = ny;
        end
        return odd;
    endfunction

    function automatic coord_t pick_coord(input bit tight);
        int r;
        r = $urandom_range(99);
        if (r < 8)
        begin
            case ($urandom_range(3))
                0: return C_MIN;
                1: return C_MAX;
                2: return C_ZERO;
                default: return C_NEG1;
            endcase
        end
        if (tight)
            return 16'(int'($urandom_range(12)) - 6);
        return 16'($urandom);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // Drive one request beat and hold it until accepted
    task automatic send_beat(input logic cmd, input logic [INDEX_BITS-1:0] index,
                             input coord_t a, input coord_t b, input coord_t c,
                             input logic pinned, input logic in_poly);
        pin_t pin;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.cmd          <= cmd;
        req_ch.vertex_index <= index;
        req_ch.coord_a      <= a;
        req_ch.coord_b      <= b;
        req_ch.coord_c      <= c;
        pin.pinned  = pinned;
        pin.in_poly = in_poly;
        staged_pins.push_back(pin);
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
    endtask

    // Drop valid and wait until every response is back; returns at a falling edge
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (owed_answers.size() != 0 || staged_pins.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic cfg_write(input logic reg_sel, input logic [APB_DATA_BITS-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (reg_sel == REG_VIEW_PLANE)
            view_sel = value[1:0];
        else
            poly_count = value[6:0];
    endtask

    // Receiver: stall at random at the current rate
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Check response beats, predict on accepted request beats, watch for hangs
    always @(posedge clk)
    begin : scoreboard
        answer_t want;
        answer_t got;
        pin_t    pin;
        longint  pt [3];
        bit      moved;
        if (!rst_n)
            quiet_cycles = 0;
        else
        begin
            moved = 1'b0;
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                moved = 1'b1;
                answers_seen++;
                got.is_inside = rsp_ch.is_inside;
                got.was_query = rsp_ch.was_query;
                if (owed_answers.size() == 0)
                    report_mismatch($sformatf("response %0d with no request outstanding",
                                              answers_seen));
                else
                begin
                    want = owed_answers.pop_front();
                    if (got.is_inside !== want.is_inside)
                        report_mismatch($sformatf("response %0d: is_inside %b, expected %b",
                                                  answers_seen, got.is_inside, want.is_inside));
                    if (got.was_query !== want.was_query)
                        report_mismatch($sformatf("response %0d: was_query %b, expected %b",
                                                  answers_seen, got.was_query, want.was_query));
                end
            end
            if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
            begin
                moved = 1'b1;
                pin = staged_pins.pop_front();
                pt[0] = plane_coord(req_ch.coord_a);
                pt[1] = plane_coord(req_ch.coord_b);
                pt[2] = plane_coord(req_ch.coord_c);
                if (req_ch.cmd == CMD_LOAD)
                begin
                    if (int'(req_ch.vertex_index) < MAX_VERTICES)
                        for (int k = 0; k < 3; k++)
                            vtx_store[req_ch.vertex_index][k] = pt[k];
                    want.is_inside = 1'b0;
                    want.was_query = 1'b0;
                end
                else
                begin
                    want.is_inside = polygon_contains(pt);
                    want.was_query = 1'b1;
                end
                if (pin.pinned)
                    want.is_inside = pin.in_poly;
                owed_answers.push_back(want);
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Stimulus: reset, directed table, random segments, final drain
    initial
    begin : stimulus
        int     r;
        int     seg;
        int     count;
        int     n_eff;
        bit     tight;
        drow_t  row;
        rst_n               <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        req_ch.valid        <= 1'b0;
        req_ch.cmd          <= CMD_LOAD;
        req_ch.vertex_index <= '0;
        req_ch.coord_a      <= '0;
        req_ch.coord_b      <= '0;
        req_ch.coord_c      <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (r = 0; r < N_DIRECTED; r++)
        begin
            row = directed_rows[r];
            if (row.kind == ROW_WRITE)
            begin
                drain();
                cfg_write(row.reg_sel, row.wdata);
            end
            else
                send_beat(row.cmd, row.index, row.a, row.b, row.c, row.pinned, row.in_poly);
        end

        // Random segments: new settings, fresh polygon, then mixed traffic
        for (seg = 0; seg < N_SEGMENTS; seg++)
        begin
            drain();
            case (seg % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 50;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 50;
                end
                default:
                begin
                    send_idle_pct = 12;
                    stall_pct     = 12;
                end
            endcase
            case (seg)
                0: count = 127;
                1: count = MAX_VERTICES;
                2: count = MIN_POLY_VERTICES;
                3: count = 0;
                4: count = MAX_VERTICES + 1;
                default:
                begin
                    r = $urandom_range(99);
                    if (r < 60)
                        count = $urandom_range(10, 3);
                    else if (r < 75)
                        count = $urandom_range(MAX_VERTICES, 11);
                    else if (r < 85)
                        count = $urandom_range(127, MAX_VERTICES + 1);
                    else
                        count = $urandom_range(2);
                end
            endcase
            cfg_write(REG_VIEW_PLANE, (seg < 4) ? 32'(seg) : 32'($urandom_range(3)));
            cfg_write(REG_VERTEX_COUNT, 32'(count));
            tight = ($urandom_range(2) == 0);
            n_eff = (count > MAX_VERTICES) ? MAX_VERTICES : count;
            // load every slot the queries will read
            for (r = 0; r < n_eff; r++)
                send_beat(CMD_LOAD, 6'(r), pick_coord(tight), pick_coord(tight),
                          pick_coord(tight), 1'b0, 1'b0);
            repeat (QUERIES_PER_SEG)
            begin
                if ($urandom_range(99) < 75)
                    send_beat(CMD_QUERY, 6'($urandom), pick_coord(tight), pick_coord(tight),
                              pick_coord(tight), 1'b0, 1'b0);
                else
                    send_beat(CMD_LOAD, 6'($urandom), pick_coord(tight), pick_coord(tight),
                              pick_coord(tight), 1'b0, 1'b0);
            end
        end

        // Wait out the last results, then a full query latency for strays
        drain();
        repeat (MAX_VERTICES + 8) @(posedge clk);
        if (mismatch_count == 0 && owed_answers.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
